[src/plce_pkg.sv]
`timescale 1ns / 1ps
package plce_pkg;
    localparam int MaxPoints = 32;
    localparam int IdxW = $clog2(MaxPoints);
    localparam int CntW = $clog2(MaxPoints + 1);

    localparam logic [1:0] CfgPointCount = 2'd0;
    localparam logic [1:0] CfgAreaWidth  = 2'd1;
    localparam logic [1:0] CfgAreaHeight = 2'd2;

    localparam logic OpWrite = 1'b0;
    localparam logic OpEval  = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [4:0]  point_index;
        logic [15:0] point_x;
        logic [15:0] point_y;
        logic [31:0] position;
    } t_req;

    typedef struct packed {
        logic [11:0] scaled_x;
        logic [11:0] scaled_y;
        logic        range_error;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_SEG_RD0, S_SEG_RD1, S_SEG_CHK,
        S_MUL, S_DIV, S_SAT, S_SCALE, S_OUT
    } t_state;
endpackage

[src/piecewise_linear_curve_eval.sv]
`timescale 1ns / 1ps
// Evaluates a piecewise-linear curve held in a 32-entry breakpoint memory. A breakpoint
// write request is taken while the block is idle and produces no response. An evaluate
// request holds the block busy through up to five binary search steps, each a memory read
// and a compare, and one final read; then the segment is read and checked. Then come a
// multiply, a restoring divider that computes |dy|*offset/dx, and the steps that saturate,
// scale and load the output register. A request that ends on the segment start or on a
// range error skips the multiply, the divide and the saturation. One request is in flight
// at a time. A finished response waits in the output register while the next request is
// processed, and an evaluate that finishes before it is taken waits for it.
module piecewise_linear_curve_eval (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  plce_pkg::t_req      i_req,
    output logic                o_valid,
    input  logic                i_ready,
    output plce_pkg::t_rsp      o_rsp,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [11:0]         i_cfg_data
);
    logic [31:0] mem [plce_pkg::MaxPoints];
    logic [31:0] r_rd;
    logic [plce_pkg::IdxW-1:0] rd_addr;
    logic rd_en, wr_en;

    plce_pkg::t_state r_state, n_state;
    logic [5:0]  r_cnt;
    logic [11:0] r_w, r_h;
    logic [15:0] r_posx;
    logic [plce_pkg::CntW-1:0] r_lo, r_hi, n_lo, n_hi;
    logic [plce_pkg::CntW-1:0] mid, used;
    logic [15:0] r_x0, r_y0, r_x1, r_y1;
    logic [31:0] r_num, n_num;
    logic [16:0] r_rem, n_rem;
    logic [15:0] r_dx;
    logic [5:0]  r_step, n_step;
    logic [15:0] r_yo, n_yo, r_xo, n_xo;
    logic        r_err, n_err;
    logic [27:0] r_sx, r_sy;
    logic        r_ov;
    plce_pkg::t_rsp r_rsp;
    logic [17:0] rem_sh;
    logic [16:0] ysum;
    logic [15:0] dyv;

    assign used = (r_cnt < 6'd2) ? plce_pkg::CntW'(2) :
        (r_cnt > 6'(plce_pkg::MaxPoints)) ? plce_pkg::CntW'(plce_pkg::MaxPoints) :
        plce_pkg::CntW'(r_cnt);
    assign mid = plce_pkg::CntW'((r_lo + r_hi) >> 1);

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[i_req.point_index[plce_pkg::IdxW-1:0]] <= {i_req.point_x, i_req.point_y};
        if (rd_en) r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 6'd2;
            r_w <= '0;
            r_h <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                plce_pkg::CfgPointCount: r_cnt <= i_cfg_data[5:0];
                plce_pkg::CfgAreaWidth:  r_w <= i_cfg_data;
                plce_pkg::CfgAreaHeight: r_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plce_pkg::S_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == plce_pkg::S_OUT && (!r_ov || i_ready)) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
    end

    assign o_ready = (r_state == plce_pkg::S_IDLE);
    assign o_valid = r_ov;
    assign o_rsp = r_rsp;
    assign dyv = (r_y1 < r_y0) ? r_y0 - r_y1 : r_y1 - r_y0;
    assign rem_sh = {r_rem, r_num[31]};

    always_comb begin
        n_state = r_state;
        n_lo = r_lo; n_hi = r_hi;
        n_num = r_num; n_rem = r_rem; n_step = r_step;
        n_yo = r_yo; n_xo = r_xo; n_err = r_err;
        rd_en = 1'b0; rd_addr = '0; wr_en = 1'b0; ysum = '0;
        case (r_state)
            plce_pkg::S_IDLE: begin
                if (i_valid) begin
                    if (i_req.opcode == plce_pkg::OpWrite) begin
                        wr_en = 1'b1;
                    end else begin
                        n_lo = '0;
                        n_hi = plce_pkg::CntW'(used - 1'b1);
                        n_state = plce_pkg::S_SRCH_RD;
                    end
                end
            end
            plce_pkg::S_SRCH_RD: begin
                if (r_lo < r_hi) begin
                    rd_en = 1'b1; rd_addr = mid[plce_pkg::IdxW-1:0];
                    n_state = plce_pkg::S_SRCH_CMP;
                end else begin
                    rd_en = 1'b1;
                    rd_addr = (r_lo == '0) ? '0 : plce_pkg::IdxW'(r_lo - 1'b1);
                    n_state = plce_pkg::S_SEG_RD0;
                end
            end
            plce_pkg::S_SRCH_CMP: begin
                if (r_posx < r_rd[31:16]) n_hi = mid;
                else n_lo = plce_pkg::CntW'(mid + 1'b1);
                n_state = plce_pkg::S_SRCH_RD;
            end
            plce_pkg::S_SEG_RD0: begin
                rd_en = 1'b1; rd_addr = r_lo[plce_pkg::IdxW-1:0];
                n_state = plce_pkg::S_SEG_RD1;
            end
            plce_pkg::S_SEG_RD1: n_state = plce_pkg::S_SEG_CHK;
            plce_pkg::S_SEG_CHK: begin
                n_xo = r_x0; n_yo = r_y0;
                if (r_lo == '0) begin
                    n_err = 1'b1; n_state = plce_pkg::S_SCALE;
                end else if (r_x1 <= r_x0 || r_posx < r_x0) begin
                    n_err = 1'b1; n_state = plce_pkg::S_SCALE;
                end else begin
                    n_err = 1'b0;
                    n_state = (r_posx == r_x0) ? plce_pkg::S_SCALE : plce_pkg::S_MUL;
                end
            end
            plce_pkg::S_MUL: begin
                n_num = 32'(dyv) * 32'(r_posx - r_x0);
                n_rem = '0; n_step = '0; n_xo = r_posx;
                n_state = plce_pkg::S_DIV;
            end
            plce_pkg::S_DIV: begin
                if (rem_sh >= {2'b0, r_dx}) begin
                    n_rem = 17'(rem_sh - {2'b0, r_dx});
                    n_num = {r_num[30:0], 1'b1};
                end else begin
                    n_rem = rem_sh[16:0];
                    n_num = {r_num[30:0], 1'b0};
                end
                n_step = 6'(r_step + 1'b1);
                if (r_step == 6'd31) n_state = plce_pkg::S_SAT;
            end
            plce_pkg::S_SAT: begin
                if (r_y1 < r_y0) begin
                    n_yo = (r_num > 32'(r_y0)) ? 16'd0 : 16'(r_y0 - r_num[15:0]);
                end else begin
                    ysum = 17'(r_y0) + 17'(r_num[15:0]);
                    n_yo = (r_num[31:16] != '0 || ysum[16]) ? 16'hFFFF : ysum[15:0];
                end
                n_state = plce_pkg::S_SCALE;
            end
            plce_pkg::S_SCALE: n_state = plce_pkg::S_OUT;
            plce_pkg::S_OUT: if (!r_ov || i_ready) n_state = plce_pkg::S_IDLE;
            default: n_state = plce_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_lo <= n_lo; r_hi <= n_hi;
        r_num <= n_num; r_rem <= n_rem; r_step <= n_step;
        r_yo <= n_yo; r_xo <= n_xo; r_err <= n_err;
        r_dx <= r_x1 - r_x0;
        if (r_state == plce_pkg::S_IDLE) r_posx <= i_req.position[31:16];
        if (r_state == plce_pkg::S_SEG_RD0) {r_x0, r_y0} <= r_rd;
        if (r_state == plce_pkg::S_SEG_RD1) {r_x1, r_y1} <= r_rd;
        if (r_state == plce_pkg::S_SCALE) begin
            r_sx <= r_xo * r_w;
            r_sy <= r_yo * r_h;
        end
        if (r_state == plce_pkg::S_OUT && (!r_ov || i_ready)) begin
            r_rsp.scaled_x <= r_sx[27:16];
            r_rsp.scaled_y <= r_sy[27:16];
            r_rsp.range_error <= r_err;
        end
    end
endmodule

[src/plce_checker.sv]
`timescale 1ns / 1ps
module plce_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_ready,
    input logic           o_valid,
    input logic           i_ready,
    input plce_pkg::t_rsp o_rsp
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rsp)) else $error("response dropped");
    a_ready_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> o_ready && !o_valid) else $error("reset state");
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_ready)) else $error("response while idle");
endmodule

bind piecewise_linear_curve_eval plce_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_rsp(o_rsp)
);

[dv/piecewise_linear_curve_eval_test.sv]
`timescale 1ns / 1ps
module piecewise_linear_curve_eval_test;
    localparam int CycleLimit = 2000000;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_valid;
    logic           o_ready;
    plce_pkg::t_req i_req;
    logic           o_valid;
    logic           i_ready;
    plce_pkg::t_rsp o_rsp;
    logic           i_cfg_we;
    logic [1:0]     i_cfg_index;
    logic [11:0]    i_cfg_data;

    piecewise_linear_curve_eval dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_req(i_req), .o_valid(o_valid), .i_ready(i_ready), .o_rsp(o_rsp),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    logic [15:0] curve_x [plce_pkg::MaxPoints];
    logic [15:0] curve_y [plce_pkg::MaxPoints];
    logic [5:0]  point_count;
    logic [11:0] area_width;
    logic [11:0] area_height;

    plce_pkg::t_rsp pending_points [$];
    int          mismatch_count;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("piecewise_linear_curve_eval regression: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatch_count++;
    endtask

    function automatic logic [11:0] scale_to_area(input logic [15:0] v, input logic [11:0] size);
        logic [27:0] prod;
        prod = v * size;
        return prod[27:16];
    endfunction

    function automatic plce_pkg::t_rsp evaluate_curve(input logic [31:0] position);
        plce_pkg::t_rsp r;
        int          lo, hi, mid, used, dx, off;
        longint      dy, q, y;
        logic [15:0] posx;
        posx = position[31:16];
        used = point_count < 2 ? 2 :
            (point_count > plce_pkg::MaxPoints ? plce_pkg::MaxPoints : int'(point_count));
        lo = 0;
        hi = used - 1;
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (posx < curve_x[mid]) hi = mid;
            else lo = mid + 1;
        end
        r.range_error = 1'b1;
        if (lo == 0) begin
            r.scaled_x = scale_to_area(curve_x[0], area_width);
            r.scaled_y = scale_to_area(curve_y[0], area_height);
            return r;
        end
        dx = int'(curve_x[lo]) - int'(curve_x[lo-1]);
        off = int'(posx) - int'(curve_x[lo-1]);
        r.scaled_x = scale_to_area(curve_x[lo-1], area_width);
        r.scaled_y = scale_to_area(curve_y[lo-1], area_height);
        if (dx <= 0 || off < 0) return r;
        r.range_error = 1'b0;
        if (off == 0) return r;
        if (curve_y[lo] < curve_y[lo-1]) begin
            dy = curve_y[lo-1] - curve_y[lo];
            q = dy * off / dx;
            y = longint'(curve_y[lo-1]) - q;
        end else begin
            dy = curve_y[lo] - curve_y[lo-1];
            q = dy * off / dx;
            y = longint'(curve_y[lo-1]) + q;
        end
        if (y < 0) y = 0;
        if (y > 65535) y = 65535;
        r.scaled_x = scale_to_area(posx, area_width);
        r.scaled_y = scale_to_area(y[15:0], area_height);
        return r;
    endfunction

    // The request stays offered after acceptance until the next request or an idle cycle
    // replaces it, so that valid changes once per clock edge at most.
    task automatic send_request(input plce_pkg::t_req req);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req <= req;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (req.opcode == plce_pkg::OpWrite) begin
            curve_x[req.point_index] = req.point_x;
            curve_y[req.point_index] = req.point_y;
        end else begin
            pending_points.push_back(evaluate_curve(req.position));
        end
    endtask

    task automatic write_point(input int idx, input int x, input int y);
        plce_pkg::t_req req;
        req = '0;
        req.opcode = plce_pkg::OpWrite;
        req.point_index = 5'(idx);
        req.point_x = 16'(x);
        req.point_y = 16'(y);
        send_request(req);
    endtask

    task automatic eval_position(input logic [31:0] position);
        plce_pkg::t_req req;
        req = '0;
        req.opcode = plce_pkg::OpEval;
        req.point_index = 5'($urandom());
        req.point_x = 16'($urandom());
        req.point_y = 16'($urandom());
        req.position = position;
        send_request(req);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [1:0] index, input int value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= 12'(value);
        @(posedge i_clk);
        case (index)
            plce_pkg::CfgPointCount: point_count = 6'(value);
            plce_pkg::CfgAreaWidth:  area_width = 12'(value);
            plce_pkg::CfgAreaHeight: area_height = 12'(value);
            default: ;
        endcase
    endtask

    task automatic apply_setting(input int count, input int width, input int height);
        drain();
        write_config(plce_pkg::CfgPointCount, count);
        write_config(plce_pkg::CfgAreaWidth, width);
        write_config(plce_pkg::CfgAreaHeight, height);
        i_cfg_we <= 1'b0;
    endtask

    // Sorted random curve filling all slots; duplicates give zero-width segments.
    task automatic load_random_curve(input bit allow_dupes);
        int xs [plce_pkg::MaxPoints];
        int span;
        span = 0;
        for (int i = 0; i < plce_pkg::MaxPoints; i++) begin
            span += allow_dupes && $urandom_range(3, 0) == 0 ? 0 : $urandom_range(4000, 1);
            xs[i] = span > 65535 ? 65535 : span;
        end
        if ($urandom_range(1, 0)) xs[0] = 0;
        for (int i = 0; i < plce_pkg::MaxPoints; i++)
            write_point(i, xs[i], $urandom_range(1, 0) ? $urandom_range(65535, 0)
                                                      : ($urandom_range(1, 0) ? 0 : 65535));
    endtask

    always @(posedge i_clk) begin
        plce_pkg::t_rsp want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_points.size() == 0) begin
                report_mismatch("unexpected response", 1, 0);
            end else begin
                want = pending_points.pop_front();
                if (o_rsp.scaled_x !== want.scaled_x)
                    report_mismatch("scaled_x", int'(o_rsp.scaled_x), int'(want.scaled_x));
                if (o_rsp.scaled_y !== want.scaled_y)
                    report_mismatch("scaled_y", int'(o_rsp.scaled_y), int'(want.scaled_y));
                if (o_rsp.range_error !== want.range_error)
                    report_mismatch("range_error", int'(o_rsp.range_error),
                                    int'(want.range_error));
            end
        end
    end

    always @(posedge i_clk) begin
        i_ready <= !hold_off && !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
    end

    task automatic test_directed();
        write_point(0, 16'h1000, 16'h0000);
        write_point(1, 16'h1000, 16'hFFFF);
        write_point(2, 16'h2000, 16'hFFFF);
        write_point(3, 16'h3000, 16'h0000);
        write_point(4, 16'hFFFF, 16'hFFFF);
        eval_position(32'h0000_0000);
        apply_setting(5, 4095, 4095);
        eval_position(32'h0FFF_FFFF);
        eval_position(32'h1000_0000);
        eval_position(32'h1800_0000);
        eval_position(32'h2000_0000);
        eval_position(32'h2800_1234);
        eval_position(32'hFFFF_FFFF);
        apply_setting(2, 4095, 4095);
        write_point(1, 16'h0800, 16'hFFFF);
        eval_position(32'hFFFF_FFFF);
        write_point(1, 16'h1000, 16'h0000);
        write_point(0, 16'h0800, 16'hFFFF);
        eval_position(32'hFFFF_0000);
        apply_setting(3, 4095, 4095);
        write_point(2, 16'h0100, 16'h8000);
        eval_position(32'h2000_0000);
        apply_setting(5, 0, 0);
        eval_position(32'h1800_0000);
        eval_position(32'h5555_AAAA);
    endtask

    task automatic test_random_curves(input int phase);
        int n;
        apply_setting($urandom_range(32, 2), $urandom_range(4095, 0), $urandom_range(4095, 0));
        load_random_curve(1'(phase % 2));
        n = 0;
        while (n < 200) begin
            if ($urandom_range(19, 0) == 0) begin
                write_point($urandom_range(31, 0), $urandom(), $urandom());
            end else begin
                eval_position($urandom());
                n++;
            end
            if (n == 100 && phase == 3) apply_setting(32, 4095, 0);
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 8; i++) eval_position($urandom());
        join
    endtask

    initial begin
        mismatch_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = plce_pkg::CfgPointCount;
        i_cfg_data = '0;
        point_count = 6'd2;
        area_width = '0;
        area_height = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                1: begin send_idle_pct = 55; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 55; end
                3: begin send_idle_pct = 34; recv_stall_pct = 34; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            test_random_curves(phase);
        end
        drain();
        if (mismatch_count == 0) begin
            $display("piecewise_linear_curve_eval regression: pass");
        end else begin
            $display("piecewise_linear_curve_eval regression: fail");
        end
        $finish;
    end
endmodule

[files.f]
src/plce_pkg.sv
src/piecewise_linear_curve_eval.sv
src/plce_checker.sv
dv/piecewise_linear_curve_eval_test.sv
